FILE: src/tna_pkg.sv
package tna_pkg;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] m;
  } tn_t;

  typedef enum logic [4:0] {
    K_ADD, K_SUB, K_NEG, K_AND, K_OR, K_XOR, K_MUL, K_LSH, K_RSH, K_ARSH,
    K_UDIV, K_SDIV, K_UMOD, K_SMOD, K_INTERSECT, K_UNION, K_RANGE, K_CAST,
    K_SUBREG, K_OVERLAP, K_IN, K_ALIGNED
  } kind_t;

  localparam tn_t ZERO_TN = '0;

  function automatic tn_t mk(input logic [63:0] v, input logic [63:0] m,
                             input logic [63:0] wm);
    tn_t r;
    r.v = v & wm;
    r.m = m & wm;
    return r;
  endfunction

  function automatic logic is_bottom(input tn_t x, input logic [63:0] wm);
    return (x.v == wm) && (x.m == wm);
  endfunction

  function automatic logic [63:0] fill_below(input logic [63:0] x,
                                             input logic [63:0] wm);
    logic [63:0] r;
    r = x & wm;
    r = r | (r >> 1);
    r = r | (r >> 2);
    r = r | (r >> 4);
    r = r | (r >> 8);
    r = r | (r >> 16);
    r = r | (r >> 32);
    return r;
  endfunction

  function automatic tn_t t_add(input tn_t a, input tn_t b, input logic [63:0] wm);
    logic [63:0] sm;
    logic [63:0] sv;
    logic [63:0] mu;
    sm = a.m + b.m;
    sv = a.v + b.v;
    mu = ((sm + sv) ^ sv) | a.m | b.m;
    return mk(sv & ~mu, mu, wm);
  endfunction

  function automatic tn_t t_sub(input tn_t a, input tn_t b, input logic [63:0] wm);
    logic [63:0] dv;
    logic [63:0] mu;
    dv = a.v - b.v;
    mu = ((dv + a.m) ^ (dv - b.m)) | a.m | b.m;
    return mk(dv & ~mu, mu, wm);
  endfunction

  function automatic tn_t t_union(input tn_t a, input tn_t b, input logic [63:0] wm);
    logic [63:0] mu;
    tn_t r;
    mu = (a.v ^ b.v) | a.m | b.m;
    if (is_bottom(a, wm)) begin
      r = b;
    end else if (is_bottom(b, wm)) begin
      r = a;
    end else begin
      r = mk(a.v & b.v & ~mu, mu, wm);
    end
    return r;
  endfunction

  function automatic tn_t get_pos(input tn_t x, input logic [63:0] wm,
                                  input logic [63:0] top);
    tn_t r;
    if ((x.v & top) != 64'd0) begin
      r = mk(wm, wm, wm);
    end else if ((x.m & top) != 64'd0) begin
      r = mk(x.v, x.m & ~top, wm);
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic tn_t get_neg(input tn_t x, input logic [63:0] wm,
                                  input logic [63:0] top);
    tn_t r;
    if ((x.v & top) != 64'd0) begin
      r = x;
    end else if ((x.m & top) != 64'd0) begin
      r = mk(x.v | top, x.m & ~top, wm);
    end else begin
      r = mk(wm, wm, wm);
    end
    return r;
  endfunction

endpackage

FILE: src/tna_div.sv
module tna_div
  import tna_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic [63:0]   dq_r;
  logic [63:0]   rem_r;
  logic [63:0]   d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [64:0]   trial;
  logic [64:0]   diff;
  logic          ge;

  assign trial = {rem_r, dq_r[63]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dq_r   <= dividend << (64 - WORD_BITS);
        rem_r  <= 64'd0;
        d_r    <= divisor;
        cnt_r  <= CW'(WORD_BITS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[63:0] : trial[63:0];
        dq_r  <= {dq_r[62:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

FILE: src/tna_mul.sv
module tna_mul
  import tna_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  tn_t  a,
  input  tn_t  b,
  output logic done,
  output tn_t  prod
);

  localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - WORD_BITS);

  tn_t  pa_r;
  tn_t  pb_r;
  tn_t  acc_r;
  logic busy_r;
  logic done_r;
  tn_t  sum;

  assign sum = t_add(acc_r, pb_r, WMASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        pa_r   <= a;
        pb_r   <= b;
        acc_r  <= ZERO_TN;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if ((pa_r.v | pa_r.m) == 64'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (pa_r.v[0]) begin
            acc_r <= sum;
          end else if (pa_r.m[0]) begin
            acc_r <= t_union(acc_r, sum, WMASK);
          end
          pa_r <= mk(pa_r.v >> 1, pa_r.m >> 1, WMASK);
          pb_r <= mk(pb_r.v << 1, pb_r.m << 1, WMASK);
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: src/tristate_number_alu.sv
// ALU over tracked tristate numbers (known value word plus unknown mask word). One item is
// taken at a time; the next is accepted as soon as the previous result sits in the output
// register. Kinds other than multiply, divide and modulo are computed combinationally in
// S_EXEC, held in res_r and moved to the output register in S_DONE. Multiply walks the first
// operand one bit per cycle in the shift-and-add unit. Unsigned divide and modulo pass
// through S_PREP, S_SUMS, the restoring divider when needed, which yields one quotient bit
// per cycle, then S_FIN and S_FLIP. Signed divide and modulo run four sign-split passes
// through that divider unless the divisor value is zero.
module tristate_number_alu
  import tna_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_value, a_mask, b_value, b_mask, shift_amount, is_32bit, byte_size, zero fill
  input  logic [271:0] in_tdata,
  // kind
  input  logic [4:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_value, result_mask, predicate, zero fill
  output logic [135:0] out_tdata
);

  localparam logic [63:0] WMASK   = {64{1'b1}} >> (64 - WORD_BITS);
  localparam logic [63:0] TOPBIT  = 64'd1 << (WORD_BITS - 1);
  localparam logic [6:0]  WB7     = 7'(WORD_BITS);
  localparam logic [63:0] LO_HALF = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] HI_HALF = (WORD_BITS > 32) ? (WMASK & ~LO_HALF) : 64'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MUL, S_PREP, S_SUMS, S_DIVW, S_FIN, S_FLIP, S_DONE
  } state_t;

  state_t       state_r;
  logic [4:0]   kind_r;
  tn_t          a_r;
  tn_t          b_r;
  logic [5:0]   sh_r;
  logic         w32_r;
  logic [3:0]   bytes_r;
  tn_t          x_r;
  tn_t          y_r;
  tn_t          hres_r;
  tn_t          acc_r;
  tn_t          res_r;
  logic         pred_r;
  logic [1:0]   p_r;
  logic         sgn_r;
  logic         mod_r;
  logic         hbot_r;
  logic         flip_r;
  logic [63:0]  xsum_r;
  logic [63:0]  ysum_r;
  logic         out_tvalid_r;
  logic [135:0] out_tdata_r;

  function automatic logic [63:0] asr(input logic [63:0] x, input logic [6:0] s,
                                      input logic [6:0] w);
    logic [63:0] mw;
    logic [63:0] xm;
    logic        sg;
    mw = {64{1'b1}} >> (7'd64 - w);
    xm = x & mw;
    sg = |(xm & (64'd1 << (w - 7'd1)));
    return sg ? (((xm >> s) | ~(mw >> s)) & mw) : (xm >> s);
  endfunction

  // kinds computed combinationally in S_EXEC
  tn_t         simp_res;
  logic        simp_pred;
  logic [63:0] tv;
  logic [63:0] tm;
  logic [6:0]  aw;
  logic [6:0]  ash;
  logic [7:0]  bsh;
  logic [63:0] ck;

  always_comb begin
    simp_res  = ZERO_TN;
    simp_pred = 1'b0;
    tv        = 64'd0;
    tm        = 64'd0;
    aw        = (w32_r && WORD_BITS > 32) ? 7'd32 : WB7;
    ash       = ({1'b0, sh_r} < aw) ? {1'b0, sh_r} : aw - 7'd1;
    bsh       = {1'b0, bytes_r, 3'b000};
    ck        = (64'd1 << bsh[5:0]) - 64'd1;
    unique case (kind_r)
      K_ADD: simp_res = t_add(a_r, b_r, WMASK);
      K_SUB: simp_res = t_sub(a_r, b_r, WMASK);
      K_NEG: simp_res = t_sub(ZERO_TN, a_r, WMASK);
      K_AND: begin
        tv       = a_r.v & b_r.v;
        simp_res = mk(tv, (a_r.v | a_r.m) & (b_r.v | b_r.m) & ~tv, WMASK);
      end
      K_OR: begin
        tv       = a_r.v | b_r.v;
        simp_res = mk(tv, (a_r.m | b_r.m) & ~tv, WMASK);
      end
      K_XOR: begin
        tm       = a_r.m | b_r.m;
        simp_res = mk((a_r.v ^ b_r.v) & ~tm, tm, WMASK);
      end
      K_LSH: begin
        if ({1'b0, sh_r} < WB7) simp_res = mk(a_r.v << sh_r, a_r.m << sh_r, WMASK);
      end
      K_RSH: begin
        if ({1'b0, sh_r} < WB7) simp_res = mk(a_r.v >> sh_r, a_r.m >> sh_r, WMASK);
      end
      K_ARSH: simp_res = mk(asr(a_r.v, ash, aw), asr(a_r.m, ash, aw), WMASK);
      K_INTERSECT: begin
        tm       = a_r.m & b_r.m;
        simp_res = mk((a_r.v | b_r.v) & ~tm, tm, WMASK);
      end
      K_UNION: simp_res = t_union(a_r, b_r, WMASK);
      K_RANGE: begin
        tm       = fill_below(a_r.v ^ b_r.v, WMASK);
        simp_res = mk(a_r.v & ~tm, tm, WMASK);
      end
      K_CAST: begin
        if (bsh >= {1'b0, WB7}) simp_res = a_r;
        else simp_res = mk(a_r.v & ck, a_r.m & ck, WMASK);
      end
      K_SUBREG: begin
        tv       = (a_r.v & HI_HALF) | (b_r.v & LO_HALF);
        simp_res = mk(tv, ((a_r.m & HI_HALF) | (b_r.m & LO_HALF)) & ~tv, WMASK);
      end
      K_OVERLAP: begin
        tm        = ~a_r.m & ~b_r.m;
        simp_pred = (a_r.v & tm) == (b_r.v & tm);
      end
      K_IN: simp_pred = ((b_r.m & ~a_r.m) == 64'd0) && (a_r.v == (b_r.v & ~a_r.m));
      K_ALIGNED: simp_pred = (b_r.v == 64'd0) || (((a_r.v | a_r.m) & (b_r.v - 64'd1)) == 64'd0);
      default: ;
    endcase
  end

  // operands of one divide pass
  tn_t  ha;
  tn_t  hb;
  tn_t  px;
  tn_t  py;
  logic pbot;
  logic pflip;

  always_comb begin
    ha = p_r[0] ? get_neg(a_r, WMASK, TOPBIT) : get_pos(a_r, WMASK, TOPBIT);
    hb = (p_r[0] ^ p_r[1]) ? get_neg(b_r, WMASK, TOPBIT) : get_pos(b_r, WMASK, TOPBIT);
    if (sgn_r) begin
      px    = ((ha.v & TOPBIT) != 64'd0) ? t_sub(ZERO_TN, ha, WMASK) : ha;
      py    = ((hb.v & TOPBIT) != 64'd0) ? t_sub(ZERO_TN, hb, WMASK) : hb;
      pbot  = is_bottom(ha, WMASK) || is_bottom(hb, WMASK);
      pflip = mod_r ? ((ha.v & TOPBIT) != 64'd0)
                    : (((ha.v & TOPBIT) != 64'd0) != ((hb.v & TOPBIT) != 64'd0));
    end else begin
      px    = a_r;
      py    = b_r;
      pbot  = 1'b0;
      pflip = 1'b0;
    end
  end

  logic [63:0] xsum;
  logic [63:0] ysum;
  logic        xc;
  logic        yc;
  logic        yz;
  logic        need_div;
  logic        div_start;
  logic [63:0] div_dividend;
  logic        div_done;
  logic [63:0] div_quot;
  logic [63:0] div_rem;

  assign xsum         = (x_r.v + x_r.m) & WMASK;
  assign ysum         = (y_r.v + y_r.m) & WMASK;
  assign xc           = x_r.m == 64'd0;
  assign yc           = y_r.m == 64'd0;
  assign yz           = y_r.v == 64'd0;
  assign need_div     = !yz && (!mod_r || (xc && yc));
  assign div_start    = (state_r == S_SUMS) && !hbot_r && need_div;
  assign div_dividend = (xc && yc) ? x_r.v : xsum;

  tna_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (y_r.v),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  logic mul_start;
  logic mul_done;
  tn_t  mul_prod;

  assign mul_start = (state_r == S_EXEC) && (kind_r == K_MUL);

  tna_mul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (a_r),
    .b     (b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // finish of one unsigned divide or modulo pass
  tn_t         fin_res;
  tn_t         mres;
  logic [63:0] low;
  logic [63:0] low2;
  logic [63:0] ym1;

  always_comb begin
    ym1  = y_r.v - 64'd1;
    low  = (ysum_r & (64'd0 - ysum_r)) - 64'd1;
    low2 = fill_below((xsum_r < ysum_r) ? xsum_r : ysum_r, WMASK);
    if (y_r.v[0] || y_r.m[0]) mres = mk(64'd0, WMASK, WMASK);
    else mres = mk(x_r.v & low, (x_r.m & low) | ~low, WMASK);
    mres = mk(mres.v & low2, mres.m & low2, WMASK);
    if (!mod_r) begin
      if (yz) fin_res = yc ? ZERO_TN : mk(64'd0, WMASK, WMASK);
      else if (xc && yc) fin_res = mk(div_quot, 64'd0, WMASK);
      else fin_res = mk(64'd0, fill_below(div_quot, WMASK), WMASK);
    end else begin
      if (yz) fin_res = yc ? x_r : mk(64'd0, WMASK, WMASK);
      else if (xc && yc) fin_res = mk(div_rem, 64'd0, WMASK);
      else if (yc && ((y_r.v & ym1) == 64'd0)) fin_res = mk(x_r.v & ym1, x_r.m & ym1, WMASK);
      else fin_res = mres;
    end
  end

  tn_t hflip;
  tn_t acc_join;

  assign hflip    = flip_r ? t_sub(ZERO_TN, hres_r, WMASK) : hres_r;
  assign acc_join = hbot_r ? acc_r : t_union(acc_r, hflip, WMASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r  <= in_tuser;
            a_r     <= mk(in_tdata[63:0], in_tdata[127:64], WMASK);
            b_r     <= mk(in_tdata[191:128], in_tdata[255:192], WMASK);
            sh_r    <= in_tdata[261:256];
            w32_r   <= in_tdata[262];
            bytes_r <= in_tdata[266:263];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          pred_r <= simp_pred;
          acc_r  <= mk(WMASK, WMASK, WMASK);
          p_r    <= 2'd0;
          sgn_r  <= (kind_r == K_SDIV) || (kind_r == K_SMOD);
          mod_r  <= (kind_r == K_UMOD) || (kind_r == K_SMOD);
          priority if (kind_r == K_MUL) begin
            state_r <= S_MUL;
          end else if ((kind_r == K_UDIV) || (kind_r == K_UMOD)) begin
            state_r <= S_PREP;
          end else if ((kind_r == K_SDIV) || (kind_r == K_SMOD)) begin
            if (b_r.v == 64'd0) begin
              if (b_r.m != 64'd0) res_r <= mk(64'd0, WMASK, WMASK);
              else if (kind_r == K_SMOD) res_r <= a_r;
              else res_r <= ZERO_TN;
              state_r <= S_DONE;
            end else begin
              state_r <= S_PREP;
            end
          end else begin
            res_r   <= simp_res;
            state_r <= S_DONE;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            res_r   <= mul_prod;
            state_r <= S_DONE;
          end
        end
        S_PREP: begin
          x_r     <= px;
          y_r     <= py;
          hbot_r  <= pbot;
          flip_r  <= pflip;
          state_r <= S_SUMS;
        end
        S_SUMS: begin
          xsum_r <= xsum;
          ysum_r <= ysum;
          priority if (hbot_r) state_r <= S_FLIP;
          else if (need_div) state_r <= S_DIVW;
          else state_r <= S_FIN;
        end
        S_DIVW: begin
          if (div_done) state_r <= S_FIN;
        end
        S_FIN: begin
          hres_r  <= fin_res;
          state_r <= S_FLIP;
        end
        S_FLIP: begin
          acc_r <= acc_join;
          if (!sgn_r || (p_r == 2'd3)) begin
            res_r   <= acc_join;
            state_r <= S_DONE;
          end else begin
            p_r     <= p_r + 2'd1;
            state_r <= S_PREP;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'd0, pred_r, res_r.m, res_r.v};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: src/tna_chk.sv
module tna_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // test kinds carry no number
  a_pred_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[127:0] == 128'd0)
    else $error("predicate with nonzero number");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[135:129] == 7'd0)
    else $error("fill bits set");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind tristate_number_alu tna_chk u_tna_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
